// ===== rtl/core/sjc_pkg.sv =====
package sjc_pkg;

    localparam int TableCapacity = 4096;
    localparam int IndexBits     = $clog2(TableCapacity);
    localparam int UsedBits      = IndexBits + 1;
    localparam int PositionBits  = 32;
    localparam int ChromBits     = 16;
    localparam int ReadsBits     = 32;
    localparam int OpLenBits     = 28;
    localparam int EntryIdxBits  = 12;

    localparam logic [7:0] DefaultMinMapq = 8'd20;

    localparam logic [3:0] CIG_M  = 4'd0;
    localparam logic [3:0] CIG_D  = 4'd2;
    localparam logic [3:0] CIG_N  = 4'd3;
    localparam logic [3:0] CIG_EQ = 4'd7;
    localparam logic [3:0] CIG_X  = 4'd8;

    localparam logic OPER_INGEST  = 1'b0;
    localparam logic OPER_READOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_NO_GAP    = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_COUNTED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_FILTERED  = 3'd4,
        ST_ENTRY     = 3'd5,
        ST_BAD_INDEX = 3'd6
    } status_t;

    typedef struct packed {
        logic [ChromBits-1:0]    chrom;
        logic [PositionBits-1:0] start;
        logic [PositionBits-1:0] stop;
        logic [ReadsBits-1:0]    reads;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DECODE,
        OP_SRD,
        OP_SCMP,
        OP_COUNT,
        OP_INS,
        OP_SHRD,
        OP_SHWR,
        OP_PUT,
        OP_RDDATA
    } dp_op_t;

    typedef enum logic [1:0] {
        K_FILTERED,
        K_NO_GAP,
        K_GAP,
        K_READOUT
    } dp_kind_t;

    typedef struct packed {
        logic   in_ready;
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic     in_valid;
        dp_kind_t kind;
        logic     idx_ok;
        logic     used_nz;
        logic     eq;
        logic     more;
        logic     full;
        logic     shift_more;
        logic     out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/sjc_if.sv =====
interface sjc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic                              first_op;
    logic [sjc_pkg::ChromBits-1:0]     chrom;
    logic [sjc_pkg::PositionBits-1:0]  read_pos;
    logic [7:0]                        map_quality;
    logic                              secondary;
    logic [3:0]                        cigar_code;
    logic [sjc_pkg::OpLenBits-1:0]     op_length;
    logic [sjc_pkg::EntryIdxBits-1:0]  entry_index;

    modport source (output valid, operation, first_op, chrom, read_pos, map_quality,
                    secondary, cigar_code, op_length, entry_index, input ready);
    modport sink (input valid, operation, first_op, chrom, read_pos, map_quality,
                  secondary, cigar_code, op_length, entry_index, output ready);
endinterface

interface sjc_out_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        status;
    logic [sjc_pkg::ChromBits-1:0]     junction_chrom;
    logic [sjc_pkg::PositionBits-1:0]  junction_start;
    logic [sjc_pkg::PositionBits-1:0]  junction_end;
    logic [sjc_pkg::ReadsBits-1:0]     junction_reads;
    logic [sjc_pkg::UsedBits-1:0]      entries_in_use;

    modport source (output valid, status, junction_chrom, junction_start, junction_end,
                    junction_reads, entries_in_use, input ready);
    modport sink (input valid, status, junction_chrom, junction_start, junction_end,
                  junction_reads, entries_in_use, output ready);
endinterface

// ===== rtl/core/sjc_ctrl.sv =====
module sjc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  sjc_pkg::dp_stat_t stat,
    output sjc_pkg::dp_cmd_t  cmd
);
    import sjc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRD,
        S_SCMP,
        S_COUNT,
        S_INS,
        S_SHIFT,
        S_SHWR,
        S_RDDATA,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (stat.kind)
                    K_READOUT: state_next = stat.idx_ok ? S_RDDATA : S_DONE;
                    K_GAP:     state_next = stat.used_nz ? S_SRD : S_INS;
                    default:   state_next = S_DONE;
                endcase
            end
            S_SRD:    state_next = S_SCMP;
            S_SCMP:
            begin
                if (stat.eq)
                    state_next = S_COUNT;
                else if (stat.more)
                    state_next = S_SRD;
                else
                    state_next = S_INS;
            end
            S_COUNT:  state_next = S_DONE;
            S_INS:    state_next = stat.full ? S_DONE : S_SHIFT;
            S_SHIFT:  state_next = stat.shift_more ? S_SHWR : S_DONE;
            S_SHWR:   state_next = S_SHIFT;
            S_RDDATA: state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        case (state_reg)
            S_IDLE:   cmd.in_ready = 1'b1;
            S_DECODE: cmd.op = OP_DECODE;
            S_SRD:    cmd.op = OP_SRD;
            S_SCMP:   cmd.op = OP_SCMP;
            S_COUNT:  cmd.op = OP_COUNT;
            S_INS:    cmd.op = OP_INS;
            S_SHIFT:  cmd.op = stat.shift_more ? OP_SHRD : OP_PUT;
            S_SHWR:   cmd.op = OP_SHWR;
            S_RDDATA: cmd.op = OP_RDDATA;
            S_DONE:   cmd.load_out = stat.out_free;
            default:  cmd.op = OP_NONE;
        endcase
    end
endmodule

// ===== rtl/core/sjc_datapath.sv =====
module sjc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sjc_pkg::dp_cmd_t  cmd,
    output sjc_pkg::dp_stat_t stat,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    sjc_in_if.sink            req,
    sjc_out_if.source         rsp
);
    import sjc_pkg::*;

    logic                    capture;
    logic [7:0]              min_mapq_reg;
    logic                    read_acc_reg;
    logic [ChromBits-1:0]    read_chrom_reg;
    logic [PositionBits-1:0] ref_pos_reg;
    logic [UsedBits-1:0]     used_reg;
    logic [UsedBits-1:0]     lo_reg;
    logic [UsedBits-1:0]     hi_reg;
    logic [UsedBits-1:0]     mid_reg;
    logic [UsedBits-1:0]     k_reg;
    logic                    oper_reg;
    logic [3:0]              code_reg;
    logic [OpLenBits-1:0]    len_reg;
    logic [EntryIdxBits-1:0] idx_reg;
    logic [PositionBits-1:0] key_start_reg;
    logic [PositionBits-1:0] key_end_reg;

    entry_t                  mem [TableCapacity];
    entry_t                  rdata_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [IndexBits-1:0]    rd_addr;
    logic [IndexBits-1:0]    wr_addr;
    entry_t                  wr_data;

    status_t                 res_status_reg;
    entry_t                  res_reg;
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    entry_t                  out_reg;
    logic [UsedBits-1:0]     out_used_reg;

    logic [PositionBits:0]   pos_first;
    logic [PositionBits-1:0] pos_first_sat;
    logic [PositionBits:0]   pos_sum;
    logic [PositionBits-1:0] pos_after;
    logic                    consumes;
    logic [UsedBits-1:0]     mid_calc;
    logic [UsedBits-1:0]     lo_new;
    logic [UsedBits-1:0]     hi_new;
    logic                    key_lt;
    logic [ReadsBits-1:0]    cnt_inc;
    entry_t                  key_entry;

    assign capture   = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;

    assign pos_first     = {1'b0, req.read_pos} + {{PositionBits{1'b0}}, 1'b1};
    assign pos_first_sat = pos_first[PositionBits] ? '1 : pos_first[PositionBits-1:0];

    assign consumes = (code_reg == CIG_M) || (code_reg == CIG_D) || (code_reg == CIG_N)
                   || (code_reg == CIG_EQ) || (code_reg == CIG_X);
    assign pos_sum   = {1'b0, ref_pos_reg} + {{(PositionBits + 1 - OpLenBits){1'b0}}, len_reg};
    assign pos_after = !consumes ? ref_pos_reg
                     : (pos_sum[PositionBits] ? '1 : pos_sum[PositionBits-1:0]);

    assign key_entry = '{chrom: read_chrom_reg, start: key_start_reg, stop: key_end_reg,
                         reads: '0};

    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    // 80-bit key compare against the stored entry
    assign key_lt   = {read_chrom_reg, key_start_reg, key_end_reg}
                    < {rdata_reg.chrom, rdata_reg.start, rdata_reg.stop};
    assign lo_new   = key_lt ? lo_reg : mid_reg + UsedBits'(1);
    assign hi_new   = key_lt ? mid_reg : hi_reg;
    assign cnt_inc  = (&rdata_reg.reads) ? rdata_reg.reads : rdata_reg.reads + ReadsBits'(1);

    always_comb
    begin
        stat.in_valid = req.valid;
        if (oper_reg == OPER_READOUT)
            stat.kind = K_READOUT;
        else if (!read_acc_reg)
            stat.kind = K_FILTERED;
        else if (code_reg == CIG_N)
            stat.kind = K_GAP;
        else
            stat.kind = K_NO_GAP;
        stat.idx_ok     = {1'b0, idx_reg} < used_reg;
        stat.used_nz    = used_reg != '0;
        stat.eq         = {read_chrom_reg, key_start_reg, key_end_reg}
                       == {rdata_reg.chrom, rdata_reg.start, rdata_reg.stop};
        stat.more       = lo_new < hi_new;
        stat.full       = used_reg >= UsedBits'(TableCapacity);
        stat.shift_more = k_reg > lo_reg;
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        mem_re  = 1'b0;
        mem_we  = 1'b0;
        rd_addr = mid_calc[IndexBits-1:0];
        wr_addr = mid_reg[IndexBits-1:0];
        wr_data = rdata_reg;
        case (cmd.op)
            OP_DECODE:
            begin
                mem_re  = oper_reg == OPER_READOUT;
                rd_addr = idx_reg[IndexBits-1:0];
            end
            OP_SRD:  mem_re = 1'b1;
            OP_COUNT:
            begin
                mem_we        = 1'b1;
                wr_data.reads = cnt_inc;
            end
            OP_SHRD:
            begin
                mem_re  = 1'b1;
                rd_addr = k_reg[IndexBits-1:0] - IndexBits'(1);
            end
            OP_SHWR:
            begin
                mem_we  = 1'b1;
                wr_addr = k_reg[IndexBits-1:0];
            end
            OP_PUT:
            begin
                mem_we        = 1'b1;
                wr_addr       = lo_reg[IndexBits-1:0];
                wr_data       = key_entry;
                wr_data.reads = ReadsBits'(1);
            end
            default: mem_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mapq_reg   <= DefaultMinMapq;
            read_acc_reg   <= 1'b0;
            read_chrom_reg <= '0;
            ref_pos_reg    <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_mapq_reg <= cfg_wdata;
            if (capture && req.operation == OPER_INGEST && req.first_op)
            begin
                read_chrom_reg <= req.chrom;
                ref_pos_reg    <= pos_first_sat;
                read_acc_reg   <= (req.map_quality >= min_mapq_reg) && !req.secondary;
            end
            if (cmd.op == OP_DECODE && oper_reg == OPER_INGEST && read_acc_reg)
                ref_pos_reg <= pos_after;
            if (cmd.op == OP_PUT)
                used_reg <= used_reg + UsedBits'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            oper_reg <= req.operation;
            code_reg <= req.cigar_code;
            len_reg  <= req.op_length;
            idx_reg  <= req.entry_index;
        end
        case (cmd.op)
            OP_DECODE:
            begin
                key_start_reg <= ref_pos_reg;
                key_end_reg   <= pos_after;
                lo_reg        <= '0;
                hi_reg        <= used_reg;
                res_reg       <= '0;
                if (oper_reg == OPER_READOUT)
                    res_status_reg <= ST_BAD_INDEX;
                else if (!read_acc_reg)
                    res_status_reg <= ST_FILTERED;
                else
                    res_status_reg <= ST_NO_GAP;
            end
            OP_SRD:  mid_reg <= mid_calc;
            OP_SCMP:
            begin
                lo_reg <= lo_new;
                hi_reg <= hi_new;
            end
            OP_COUNT:
            begin
                res_status_reg <= ST_COUNTED;
                res_reg        <= '{chrom: read_chrom_reg, start: key_start_reg,
                                    stop: key_end_reg, reads: cnt_inc};
            end
            OP_INS:
            begin
                res_status_reg <= ST_FULL;
                res_reg        <= key_entry;
                k_reg          <= used_reg;
            end
            OP_SHWR: k_reg <= k_reg - UsedBits'(1);
            OP_PUT:
            begin
                res_status_reg <= ST_INSERTED;
                res_reg        <= '{chrom: read_chrom_reg, start: key_start_reg,
                                    stop: key_end_reg, reads: ReadsBits'(1)};
            end
            OP_RDDATA:
            begin
                res_status_reg <= ST_ENTRY;
                res_reg        <= rdata_reg;
            end
            default: res_status_reg <= res_status_reg;
        endcase
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_reg        <= res_reg;
            out_used_reg   <= used_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.junction_chrom = out_reg.chrom;
    assign rsp.junction_start = out_reg.start;
    assign rsp.junction_end   = out_reg.stop;
    assign rsp.junction_reads = out_reg.reads;
    assign rsp.entries_in_use = out_used_reg;
endmodule

// ===== rtl/core/splice_junction_counter_top.sv =====
// Splice junction counter.
// req carries one word per CIGAR operation (operation = 0) or one table
// readout (operation = 1); rsp returns exactly one result word per req word.
// cfg_we/cfg_wdata write the minimum mapping quality; write only when idle.
// One word is in flight at a time: req.ready is high only while the
// controller sits idle.
// From accept, filtered reads, non-gap operations and bad-index readouts
// pass through DECODE and DONE; a readout that returns an entry adds RDDATA
// between them. The next word can be accepted in the cycle after the previous
// result is loaded. A gap runs a binary search over the sorted table, each
// probe a registered table read (SRD) and then a compare (SCMP), up to 13
// probes; a new junction then shifts every later entry up by one, each entry
// moved by a read then a write on the same table, and the new entry is then
// written at its place.
// A finished result sits in the output register; the next word is accepted
// while it waits, and its own result waits until rsp.ready frees the register.
// Reset empties the table count, clears the read state and sets the quality
// threshold to 20; table contents are not cleared, no clearing pass needed.
module splice_junction_counter_top (
    input  logic       clk,
    input  logic       rst_n,
    sjc_in_if.sink     req,
    sjc_out_if.source  rsp,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import sjc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sjc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    sjc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );
endmodule

// ===== rtl/core/sjc_checker.sv =====
module sjc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [2:0]                   status,
    input logic [sjc_pkg::ChromBits-1:0] junction_chrom,
    input logic [sjc_pkg::ReadsBits-1:0] junction_reads,
    input logic [sjc_pkg::UsedBits-1:0]  entries_in_use
);
    import sjc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_no_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_GAP || status == ST_FILTERED
                      || status == ST_BAD_INDEX)
        |-> junction_reads == '0 && junction_chrom == '0)
        else $error("non-junction word carries junction data");

    a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INSERTED |-> junction_reads == ReadsBits'(1)
                                             && entries_in_use != '0)
        else $error("insert reported with bad count");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_in_use <= UsedBits'(TableCapacity))
        else $error("table usage beyond capacity");
endmodule

bind splice_junction_counter_top sjc_checker u_sjc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .junction_chrom (rsp.junction_chrom),
    .junction_reads (rsp.junction_reads),
    .entries_in_use (rsp.entries_in_use)
);

// ===== tb/sv/tb.sv =====
module tb;
    import sjc_pkg::*;

    typedef struct packed {
        logic        operation;
        logic        first_op;
        logic [15:0] chrom;
        logic [31:0] read_pos;
        logic [7:0]  map_quality;
        logic        secondary;
        logic [3:0]  cigar_code;
        logic [27:0] op_length;
        logic [11:0] entry_index;
    } word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] jchrom;
        logic [31:0] jstart;
        logic [31:0] jend;
        logic [31:0] jreads;
        logic [12:0] used;
    } result_t;

    localparam int WatchdogLimit = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    sjc_in_if  req();
    sjc_out_if rsp();

    splice_junction_counter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // junction table mirror
    logic [15:0] jt_chrom [TableCapacity];
    logic [31:0] jt_start [TableCapacity];
    logic [31:0] jt_end   [TableCapacity];
    logic [31:0] jt_count [TableCapacity];
    int unsigned jt_used;
    logic [31:0] cur_pos;
    logic [15:0] cur_chrom;
    logic        cur_ok;
    logic [7:0]  min_mapq;

    word_t   pending_words[$];
    result_t expected_results[$];
    int      mismatches, n_words, n_results, n_gaps;
    int      idle_cycles;

    function automatic logic [31:0] sat_pos(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // -1/0/1 ordering of key against entry i
    function automatic int key_order(int i, logic [15:0] c, logic [31:0] s, logic [31:0] e);
        if (c != jt_chrom[i]) return (c < jt_chrom[i]) ? -1 : 1;
        if (s != jt_start[i]) return (s < jt_start[i]) ? -1 : 1;
        if (e != jt_end[i]) return (e < jt_end[i]) ? -1 : 1;
        return 0;
    endfunction

    function automatic result_t predict_junction_result(word_t w);
        result_t r;
        int lo, hi, mid, o;
        logic [31:0] b, a;
        logic gap_code;
        logic consumes;
        r = '0;
        if (w.operation == OPER_READOUT) begin
            if (w.entry_index < jt_used) begin
                r.status = ST_ENTRY;
                r.jchrom = jt_chrom[w.entry_index];
                r.jstart = jt_start[w.entry_index];
                r.jend = jt_end[w.entry_index];
                r.jreads = jt_count[w.entry_index];
            end
            else
                r.status = ST_BAD_INDEX;
            r.used = 13'(jt_used);
            return r;
        end
        if (w.first_op) begin
            cur_chrom = w.chrom;
            cur_pos = sat_pos(w.read_pos, 32'd1);
            cur_ok = (w.map_quality >= min_mapq) && !w.secondary;
        end
        r.used = 13'(jt_used);
        if (!cur_ok) begin
            r.status = ST_FILTERED;
            return r;
        end
        consumes = w.cigar_code == CIG_M || w.cigar_code == CIG_D || w.cigar_code == CIG_N
                   || w.cigar_code == CIG_EQ || w.cigar_code == CIG_X;
        b = cur_pos;
        a = consumes ? sat_pos(b, {4'd0, w.op_length}) : b;
        cur_pos = a;
        gap_code = w.cigar_code == CIG_N;
        if (!gap_code) begin
            r.status = ST_NO_GAP;
            return r;
        end
        r.jchrom = cur_chrom;
        r.jstart = b;
        r.jend = a;
        lo = 0;
        hi = jt_used;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            o = key_order(mid, cur_chrom, b, a);
            if (o == 0) begin
                if (jt_count[mid] != 32'hFFFF_FFFF) jt_count[mid]++;
                r.status = ST_COUNTED;
                r.jreads = jt_count[mid];
                return r;
            end
            if (o < 0) hi = mid; else lo = mid + 1;
        end
        if (jt_used >= TableCapacity) begin
            r.status = ST_FULL;
            return r;
        end
        for (int k = jt_used; k > lo; k--) begin
            jt_chrom[k] = jt_chrom[k-1];
            jt_start[k] = jt_start[k-1];
            jt_end[k] = jt_end[k-1];
            jt_count[k] = jt_count[k-1];
        end
        jt_chrom[lo] = cur_chrom;
        jt_start[lo] = b;
        jt_end[lo] = a;
        jt_count[lo] = 32'd1;
        jt_used++;
        r.status = ST_INSERTED;
        r.jreads = 32'd1;
        r.used = 13'(jt_used);
        return r;
    endfunction

    // driver: bursts and gaps; prediction taken at accept, before the pop
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.operation <= 1'b0;
            req.first_op <= 1'b0;
            req.chrom <= '0;
            req.read_pos <= '0;
            req.map_quality <= '0;
            req.secondary <= 1'b0;
            req.cigar_code <= '0;
            req.op_length <= '0;
            req.entry_index <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
            begin
                expected_results.push_back(predict_junction_result(pending_words[0]));
                void'(pending_words.pop_front());
                n_words++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                {req.operation, req.first_op, req.chrom, req.read_pos, req.map_quality,
                 req.secondary, req.cigar_code, req.op_length, req.entry_index}
                    <= pending_words[0];
                req.valid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    // monitor with its own stall pattern
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.junction_chrom, rsp.junction_start, rsp.junction_end,
                       rsp.junction_reads, rsp.entries_in_use};
                n_results++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status == ST_INSERTED || want.status == ST_COUNTED) n_gaps++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d c=%0d s=%0d e=%0d r=%0d u=%0d",
                                     want.status, want.jchrom, want.jstart, want.jend,
                                     want.jreads, want.used,
                                     "  got st=%0d c=%0d s=%0d e=%0d r=%0d u=%0d",
                                     got.status, got.jchrom, got.jstart, got.jend,
                                     got.jreads, got.used);
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            rsp.ready <= (stall_phase >= 48) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic word_t ingest_word(logic first, logic [3:0] code, logic [27:0] len);
        word_t w;
        w = '0;
        w.operation = OPER_INGEST;
        w.first_op = first;
        w.cigar_code = code;
        w.op_length = len;
        w.chrom = 16'($urandom);
        w.read_pos = $urandom;
        w.map_quality = 8'($urandom);
        w.secondary = 1'($urandom);
        w.entry_index = 12'($urandom);
        return w;
    endfunction

    function automatic word_t read_head(logic [15:0] c, logic [31:0] p, logic [7:0] q,
                                        logic s, logic [3:0] code, logic [27:0] len);
        word_t w;
        w = ingest_word(1'b1, code, len);
        w.chrom = c;
        w.read_pos = p;
        w.map_quality = q;
        w.secondary = s;
        return w;
    endfunction

    function automatic word_t readout_word(logic [11:0] idx);
        word_t w;
        w = ingest_word(1'b0, 4'($urandom), 28'($urandom));
        w.operation = OPER_READOUT;
        w.entry_index = idx;
        return w;
    endfunction

    task automatic drain_then_write(logic [7:0] q);
        while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
        repeat (5) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_mapq = q;
    endtask

    // a read of random CIGAR words, some with codes 9-15; small chrom/pos pools give repeats
    task automatic queue_random_read();
        logic [15:0] c;
        logic [31:0] p;
        int n;
        word_t w;
        c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        p = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 40) * 100);
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            w = ingest_word(i == 0, 4'($urandom_range(0, 9)), 28'($urandom_range(0, 60)));
            if ($urandom_range(0, 2) == 0) w.cigar_code = CIG_N;
            if ($urandom_range(0, 30) == 0) w.cigar_code = 4'($urandom_range(9, 15));
            if ($urandom_range(0, 40) == 0) w.op_length = 28'($urandom);
            if (i == 0)
            begin
                w.chrom = c;
                w.read_pos = p;
                w.map_quality = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd60;
                w.secondary = ($urandom_range(0, 9) == 0);
            end
            pending_words.push_back(w);
        end
    endtask

    initial
    begin
        mismatches = 0;
        n_words = 0;
        n_results = 0;
        n_gaps = 0;
        idle_cycles = 0;
        jt_used = 0;
        cur_pos = 0;
        cur_chrom = 0;
        cur_ok = 0;
        min_mapq = DefaultMinMapq;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ops before any read, bad index, filters, extremes
        pending_words.push_back(ingest_word(1'b0, CIG_N, 28'd5));
        pending_words.push_back(readout_word(12'd0));
        pending_words.push_back(readout_word(12'hFFF));
        pending_words.push_back(read_head(16'd1, 32'd100, 8'd19, 1'b0, CIG_N, 28'd50));
        pending_words.push_back(read_head(16'd1, 32'd100, 8'd255, 1'b1, CIG_N, 28'd50));
        pending_words.push_back(read_head(16'd1, 32'd100, 8'd20, 1'b0, CIG_M, 28'd10));
        for (int code = 0; code < 16; code++)
            pending_words.push_back(ingest_word(1'b0, 4'(code), 28'd7));
        pending_words.push_back(ingest_word(1'b0, CIG_N, 28'd0));
        pending_words.push_back(read_head(16'hFFFF, 32'hFFFF_FFFE, 8'd255, 1'b0,
                                          CIG_N, 28'hFFF_FFFF));
        pending_words.push_back(read_head(16'd0, 32'd0, 8'd20, 1'b0, CIG_N, 28'hFFF_FFFF));
        pending_words.push_back(read_head(16'd0, 32'd0, 8'd20, 1'b0, CIG_N, 28'hFFF_FFFF));
        for (int i = 0; i < 3; i++) pending_words.push_back(readout_word(12'(i)));

        drain_then_write(8'd0);
        for (int i = 0; i < 450; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                pending_words.push_back(readout_word(12'($urandom_range(0, 40))));
            else if ($urandom_range(0, 30) == 0)
                pending_words.push_back(readout_word(12'($urandom)));
            else queue_random_read();
            if (i % 50 == 0)
                while (pending_words.size() > 20) @(posedge clk);
        end
        drain_then_write(8'd255);
        for (int i = 0; i < 60; i++) queue_random_read();
        drain_then_write(8'd60);
        for (int i = 0; i < 100; i++)
        begin
            queue_random_read();
            pending_words.push_back(readout_word(12'($urandom_range(0, 60))));
        end
        drain_then_write(8'd20);
        for (int i = 0; i < 50; i++) pending_words.push_back(readout_word(12'($urandom)));

        while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d words, %0d results, %0d recorded junctions, table at %0d",
                 n_words, n_results, n_gaps, jt_used);
        $display("quality thresholds 20, 0, 255, 60; mismatches %0d", mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
